// ===== rtl/srtf_pkg.sv =====
// Package of shared types, constants and state codes for the SRTF scheduler.
package srtf_pkg;

   // Default table depth.
   localparam int SRTF_MAX_PROCS = 16;

   // Request mode codes.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Input transaction.
   typedef struct packed {
      logic        mode;
      logic [15:0] arrival_time;
      logic [15:0] burst_time;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic        ran;
      logic [3:0]  process_index;
      logic        finished;
      logic [31:0] completion_time;
      logic [31:0] turnaround;
      logic [31:0] waiting;
      logic        all_done;
   } rsp_type;

   // Candidate handed from cell to cell during a scan.
   typedef struct packed {
      logic        live;
      logic        valid;
      logic [15:0] rem;
      logic [15:0] burst;
      logic [15:0] arrival;
   } tok_type;

   // Commands broadcast from the controller to every cell.
   typedef struct packed {
      logic        wr;
      logic        dec;
      logic [15:0] arrival;
      logic [15:0] burst;
   } ctl_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_REPORT
   } state_type;

endpackage

// ===== rtl/srtf_preemptive_scheduler.sv =====
// Top level of the preemptive shortest-remaining-time-first scheduler.
// A load transaction is taken while idle; busy stays low and no result is given.
// During a tick busy is high: the candidate walks the chain of cells one cell per
// cycle, then the apply step updates the entry and the report step computes times.
// The result strobe is high for one cycle after the tick completes; the receiver
// cannot stall. Synchronous reset empties the table and clears the time counter.
module srtf_preemptive_scheduler #(
   parameter int MAX_PROCS = srtf_pkg::SRTF_MAX_PROCS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  srtf_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output srtf_pkg::rsp_type rsp_payload
);
   import srtf_pkg::*;

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int XW    = (IDX_W > 4) ? IDX_W : 4;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] loaded_ff, loaded_in;
   logic [CNT_W-1:0] finished_ff, finished_in;
   logic [31:0]      tick_ff, tick_in;
   tok_type          win_ff;
   logic [IDX_W-1:0] win_idx_ff;
   logic [31:0]      tat_ff;
   logic             rsp_strobe_ff;
   rsp_type          rsp_ff;
   ctl_type          ctl;
   logic [IDX_W-1:0] sel_idx;
   logic             accept;
   logic             go;

   tok_type          tok   [MAX_PROCS+1];
   logic [IDX_W-1:0] idx_c [MAX_PROCS+1];

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign go          = accept && (req_payload.mode == MODE_TICK);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // Head of the chain: an empty candidate, live only when a tick starts.
   always_comb begin
      tok[0]       = '0;
      tok[0].live  = go;
      idx_c[0]     = '0;
   end

   // Chain of table cells.
   for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
      srtf_cell #(
         .IDX   (i),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .sel_idx      (sel_idx),
         .loaded_count (loaded_ff),
         .current_tick (tick_ff),
         .tok_in       (tok[i]),
         .idx_in       (idx_c[i]),
         .tok_out_ff   (tok[i+1]),
         .idx_out_ff   (idx_c[i+1])
      );
   end

   // Next state, cell commands and counter updates.
   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      finished_in  = finished_ff;
      tick_in      = tick_ff;
      ctl.wr       = 1'b0;
      ctl.dec      = 1'b0;
      ctl.arrival  = req_payload.arrival_time;
      ctl.burst    = (req_payload.burst_time == 16'd0) ? 16'd1 : req_payload.burst_time;
      sel_idx      = loaded_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_payload.mode == MODE_TICK) begin
                  state_in = ST_SCAN;
               end else if (loaded_ff < CNT_W'(MAX_PROCS)) begin
                  ctl.wr    = 1'b1;
                  loaded_in = loaded_ff + CNT_W'(1);
               end
            end
         end
         ST_SCAN: begin
            if (tok[MAX_PROCS].live) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            sel_idx = win_idx_ff;
            ctl.dec = win_ff.valid;
            if (tick_ff != 32'hFFFF_FFFF) begin
               tick_in = tick_ff + 32'd1;
            end
            if (win_ff.valid && (win_ff.rem == 16'd1)) begin
               finished_in = finished_ff + CNT_W'(1);
            end
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         loaded_ff     <= '0;
         finished_ff   <= '0;
         tick_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         loaded_ff     <= loaded_in;
         finished_ff   <= finished_in;
         tick_ff       <= tick_in;
         rsp_strobe_ff <= (state_ff == ST_REPORT);
      end
   end

   // Capture the winner at the end of the scan and its turnaround after the update.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_SCAN) && tok[MAX_PROCS].live) begin
         win_ff     <= tok[MAX_PROCS];
         win_idx_ff <= idx_c[MAX_PROCS];
      end
      if (state_ff == ST_APPLY) begin
         tat_ff <= tick_in - {16'd0, win_ff.arrival};
      end
   end

   // Build the result transaction.
   always_ff @(posedge clock) begin
      logic [XW-1:0] wide_idx;
      logic          fin;
      wide_idx = XW'(win_idx_ff);
      fin      = win_ff.valid && (win_ff.rem == 16'd1);
      if (state_ff == ST_REPORT) begin
         rsp_ff.ran             <= win_ff.valid;
         rsp_ff.process_index   <= win_ff.valid ? wide_idx[3:0] : 4'd0;
         rsp_ff.finished        <= fin;
         rsp_ff.completion_time <= fin ? tick_ff : 32'd0;
         rsp_ff.turnaround      <= fin ? tat_ff : 32'd0;
         rsp_ff.waiting         <= (fin && (tat_ff >= {16'd0, win_ff.burst})) ?
                                   (tat_ff - {16'd0, win_ff.burst}) : 32'd0;
         rsp_ff.all_done        <= (finished_ff == loaded_ff);
      end
   end

   // A result is only ever strobed straight after the report step.
   a_strobe_after_report: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_REPORT)
      else $error("result strobe without report step");

   // Two results never follow each other in consecutive cycles.
   a_no_double_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // More processes can never finish than were loaded.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      finished_ff <= loaded_ff)
      else $error("finished count above loaded count");

   // A finished report always names a process that ran.
   a_finished_ran: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.finished) |-> rsp_payload.ran)
      else $error("finished without a running process");

endmodule

// ===== rtl/srtf_cell.sv =====
// One table entry of the scheduler with its stage of the candidate chain.
module srtf_cell #(
   parameter int IDX      = 0,
   parameter int IDX_W    = 4,
   parameter int CNT_W    = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  srtf_pkg::ctl_type   ctl,
   input  logic [IDX_W-1:0]    sel_idx,
   input  logic [CNT_W-1:0]    loaded_count,
   input  logic [31:0]         current_tick,
   input  srtf_pkg::tok_type   tok_in,
   input  logic [IDX_W-1:0]    idx_in,
   output srtf_pkg::tok_type   tok_out_ff,
   output logic [IDX_W-1:0]    idx_out_ff
);
   import srtf_pkg::*;

   logic [15:0] arr_ff;
   logic [15:0] bst_ff;
   logic [15:0] rem_ff;
   logic        here;
   logic        eligible;
   logic        better;
   tok_type     tok_in_next;
   logic [IDX_W-1:0] idx_in_next;

   assign here = (sel_idx == IDX_W'(IDX));

   // Entry storage: written on load, decremented when this entry runs.
   always_ff @(posedge clock) begin
      if (ctl.wr && here) begin
         arr_ff <= ctl.arrival;
         bst_ff <= ctl.burst;
         rem_ff <= ctl.burst;
      end else if (ctl.dec && here) begin
         rem_ff <= rem_ff - 16'd1;
      end
   end

   // The entry competes when loaded, arrived and unfinished; strict compares keep
   // the lower index on a full tie because the scan runs in ascending order.
   always_comb begin
      eligible = (CNT_W'(IDX) < loaded_count) && (rem_ff != 16'd0) &&
                 ({16'd0, arr_ff} <= current_tick);
      better   = !tok_in.valid || (rem_ff < tok_in.rem) ||
                 ((rem_ff == tok_in.rem) && (bst_ff < tok_in.burst));
      tok_in_next = tok_in;
      idx_in_next = idx_in;
      if (eligible && better) begin
         tok_in_next.valid   = 1'b1;
         tok_in_next.rem     = rem_ff;
         tok_in_next.burst   = bst_ff;
         tok_in_next.arrival = arr_ff;
         idx_in_next         = IDX_W'(IDX);
      end
   end

   // Hand the candidate on to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_out_ff.live <= 1'b0;
      end else begin
         tok_out_ff.live <= tok_in_next.live;
      end
      tok_out_ff.valid   <= tok_in_next.valid;
      tok_out_ff.rem     <= tok_in_next.rem;
      tok_out_ff.burst   <= tok_in_next.burst;
      tok_out_ff.arrival <= tok_in_next.arrival;
      idx_out_ff         <= idx_in_next;
   end

endmodule

// ===== test/srtf_preemptive_scheduler_tb.sv =====
// Self-checking testbench for the preemptive shortest-remaining-time-first scheduler.
module srtf_preemptive_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srtf_pkg::*;

   localparam int TABLE_DEPTH  = SRTF_MAX_PROCS;
   localparam int RANDOM_ITEMS = 1600;

   // Scheduler predictor and store of expected tick reports.
   class srtf_scoreboard;
      logic [15:0] arrival_tab[TABLE_DEPTH];
      logic [15:0] burst_tab[TABLE_DEPTH];
      logic [15:0] remaining_tab[TABLE_DEPTH];
      int unsigned loaded;
      int unsigned completed;
      logic [31:0] sched_time;
      rsp_type     pending_reports[$];
      int unsigned fault_count;

      function new();
         loaded      = 0;
         completed   = 0;
         sched_time  = '0;
         fault_count = 0;
      endfunction

      // Records an accepted transaction and predicts the report that a tick gives.
      function void note_request(req_type r);
         rsp_type     rep;
         int          pick;
         logic [15:0] burst;
         logic [31:0] turn;
         pick = -1;
         if (r.mode == MODE_LOAD) begin
            burst = (r.burst_time == 16'd0) ? 16'd1 : r.burst_time;
            if (loaded < TABLE_DEPTH) begin
               arrival_tab[loaded]   = r.arrival_time;
               burst_tab[loaded]     = burst;
               remaining_tab[loaded] = burst;
               loaded++;
            end
            return;
         end
         rep = '0;
         // Least remaining time first; ties to the shorter burst, then the lower index.
         for (int i = 0; i < loaded; i++) begin
            if (remaining_tab[i] == 16'd0 || {16'd0, arrival_tab[i]} > sched_time)
               continue;
            if (pick < 0 || remaining_tab[i] < remaining_tab[pick] ||
                (remaining_tab[i] == remaining_tab[pick] && burst_tab[i] < burst_tab[pick]))
               pick = i;
         end
         if (sched_time != 32'hFFFF_FFFF)
            sched_time++;
         if (pick >= 0) begin
            remaining_tab[pick]--;
            rep.ran           = 1'b1;
            rep.process_index = pick[3:0];
            if (remaining_tab[pick] == 16'd0) begin
               turn = sched_time - {16'd0, arrival_tab[pick]};
               completed++;
               rep.finished        = 1'b1;
               rep.completion_time = sched_time;
               rep.turnaround      = turn;
               rep.waiting = (turn >= {16'd0, burst_tab[pick]}) ?
                             turn - {16'd0, burst_tab[pick]} : 32'd0;
            end
         end
         rep.all_done = (completed == loaded);
         pending_reports = {pending_reports, rep};
      endfunction

      function void flag(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: %s expected %0h, got %0h", $realtime, field, want, got);
         end
      endfunction

      // Compares a report from the block with the oldest prediction.
      function void check_report(rsp_type got);
         rsp_type want;
         if (pending_reports.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: report with none expected: %0h", $realtime, got);
            return;
         end
         want = pending_reports.pop_front();
         flag("ran", want.ran, got.ran);
         flag("process_index", want.process_index, got.process_index);
         flag("finished", want.finished, got.finished);
         flag("completion_time", want.completion_time, got.completion_time);
         flag("turnaround", want.turnaround, got.turnaround);
         flag("waiting", want.waiting, got.waiting);
         flag("all_done", want.all_done, got.all_done);
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_strobe;
   rsp_type rsp;

   srtf_scoreboard sb = new();

   srtf_preemptive_scheduler #(
      .MAX_PROCS(TABLE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Every report strobe is checked at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_report(rsp);
   end

   // Presents one transaction, after an optional random gap, and waits for its acceptance.
   task automatic send_item(input req_type r, input bit may_idle);
      int gap;
      gap = 0;
      if (may_idle) begin
         while ($urandom_range(0, 99) < 32)
            gap++;
         if ($urandom_range(0, 15) == 0)
            gap += $urandom_range(1, 24);
      end
      repeat (gap) begin
         start <= 1'b0;
         req   <= '{mode: 1'($urandom), arrival_time: 16'($urandom),
                    burst_time: 16'($urandom)};
         @(posedge clock);
      end
      start <= 1'b1;
      req   <= r;
      do
         @(posedge clock);
      while (busy);
      sb.note_request(r);
   endtask

   task automatic send_load(input logic [15:0] arrival, input logic [15:0] burst,
                            input bit may_idle);
      send_item('{mode: MODE_LOAD, arrival_time: arrival, burst_time: burst}, may_idle);
   endtask

   task automatic send_tick(input bit may_idle);
      send_item('{mode: MODE_TICK, arrival_time: 16'($urandom), burst_time: 16'($urandom)},
                may_idle);
   endtask

   // Stimulus and end of run.
   initial begin
      int          counted;
      int          roll;
      bit          may_idle;
      logic [31:0] arrival;
      logic [15:0] burst;
      start <= 1'b0;
      req   <= '0;
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Empty table: idle ticks with all processes counted as done.
      send_tick(1'b1);
      send_tick(1'b1);
      // Time is now 2. The second load has a zero burst, stored as one.
      // The third and fourth tie with the first on remaining time, and with each other
      // on burst too; the fifth arrives later and preempts.
      send_load(16'd2, 16'd3, 1'b1);
      send_load(16'd3, 16'd0, 1'b1);
      send_load(16'd3, 16'd2, 1'b1);
      send_load(16'd3, 16'd2, 1'b1);
      send_load(16'd6, 16'd1, 1'b1);
      repeat (11) send_tick(1'b1);

      // Random part: mostly ticks, with loads that fill the table over the run.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         roll     = $urandom_range(0, 99);
         may_idle = !(counted >= 600 && counted < 900);
         if (sb.loaded < TABLE_DEPTH && roll < 3) begin
            if (sb.loaded == TABLE_DEPTH - 2)
               send_load(16'h0000, 16'hFFFF, may_idle);
            else if (sb.loaded == TABLE_DEPTH - 1)
               send_load(16'hFFFF, 16'hFFFF, may_idle);
            else begin
               arrival = sb.sched_time + $urandom_range(0, 40);
               if ($urandom_range(0, 9) == 0)
                  burst = 16'd0;
               else if ($urandom_range(0, 7) == 0)
                  burst = 16'($urandom_range(1, 400));
               else
                  burst = 16'($urandom_range(1, 10));
               send_load(arrival[15:0], burst, may_idle);
            end
            counted++;
         end else if (sb.loaded == TABLE_DEPTH && roll < 2) begin
            // Load into a full table: ignored by the block.
            send_load(16'($urandom), 16'($urandom), may_idle);
         end else begin
            send_tick(may_idle);
            counted++;
         end
      end
      start <= 1'b0;

      while (sb.pending_reports.size() != 0)
         @(posedge clock);
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (sb.fault_count == 0 && sb.pending_reports.size() == 0)
         $display("srtf_preemptive_scheduler_tb: PASS");
      else
         $display("srtf_preemptive_scheduler_tb: FAIL");
      $finish;
   end

   // Run limit well beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("srtf_preemptive_scheduler_tb: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/srtf_pkg.sv
rtl/srtf_cell.sv
rtl/srtf_preemptive_scheduler.sv
test/srtf_preemptive_scheduler_tb.sv
